>>> rtl/rule_transition_time_macros.svh
// assertion macros shared by the rule_transition_time checks
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef RULE_TRANSITION_TIME_MACROS_SVH
`define RULE_TRANSITION_TIME_MACROS_SVH

// check sampled on the rising clock, switched off while reset is held
`define RTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rule_transition_time: check failed");

// check that also holds while reset is held
`define RTT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rule_transition_time: reset check failed");

`endif

>>> rtl/rtt_pkg.sv
// types and constants for the rule transition time pipeline
// used by rtt_days, rtt_adjust and the top level; depends on nothing
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int TOD_W   = 17;
  localparam int OUT_W   = 32;

  // signed working width of all second sums, wide enough for any input
  localparam int SW      = 42;
  // signed day count width
  localparam int DAYS_W  = 25;
  // non-negative day count used for the weekday
  localparam int X_W     = 23;
  // days before a month
  localparam int MD_W    = 9;

  localparam int unsigned YEAR_DAYS     = 365;
  // 365 * 1970 plus the leap bias and leap days before the epoch
  localparam int unsigned YEAR_OFFSET   = 719624;
  // weekday bias: epoch weekday, minus one for the day of month, plus a multiple of 7
  localparam int unsigned WD_OFFSET     = 721003;
  localparam int unsigned LEAP_BIAS_N   = 399;

  // reciprocal of 25, exact for the ranges used here
  localparam int unsigned M25      = 5243;
  localparam int          M25_SH   = 17;
  // reciprocal of 7 for values below 2^23
  localparam int unsigned M7       = 9586981;
  localparam int          M7_SH    = 26;

  localparam logic signed [SW-1:0] SECS_SW = SW'(86400);

  localparam logic [MD_W-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
  localparam logic [WDAY_W-1:0]  NO_WEEKDAY = 3'd7;

  typedef enum logic [1:0] {
    DC_FIXED     = 2'd0,
    DC_ON_AFTER  = 2'd1,
    DC_ON_BEFORE = 2'd2,
    DC_FIXED_ALT = 2'd3
  } day_code_e;

  // request after the day count stages
  typedef struct packed {
    logic signed [SW-1:0] s1;
    logic signed [SW-1:0] md_s;
    logic signed [SW-1:0] dm_s;
    logic [X_W-1:0]       x;
    day_code_e            code;
    logic [WDAY_W-1:0]    target;
    logic [TOD_W-1:0]     tod;
  } days_t;

endpackage

>>> rtl/rtt_days.sv
// day count stages: year, month and day of month to seconds and weekday operand
// depends on rtt_pkg
`timescale 1ns / 1ps

module rtt_days (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [rtt_pkg::YEAR_W-1:0]    year_i,
  input  logic [rtt_pkg::MONTH_W-1:0]   month_i,
  input  logic [1:0]                    day_code_i,
  input  logic [rtt_pkg::DOM_W-1:0]     day_of_month_i,
  input  logic [rtt_pkg::WDAY_W-1:0]    weekday_i,
  input  logic [rtt_pkg::TOD_W-1:0]     time_of_day_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output rtt_pkg::days_t                days_o
);

  localparam int DW = rtt_pkg::DAYS_W;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: quotients by 25, 100 and 400
  logic [14:0] n_sum;
  logic [25:0] p100;
  logic [23:0] p400;
  logic [26:0] p25;
  logic [3:0]  m_d;

  logic [rtt_pkg::YEAR_W-1:0]  y1_q;
  logic [rtt_pkg::MONTH_W-1:0] m1_q;
  logic [1:0]                  code1_q;
  logic [rtt_pkg::DOM_W-1:0]   dom1_q;
  logic [rtt_pkg::WDAY_W-1:0]  tgt1_q;
  logic [rtt_pkg::TOD_W-1:0]   tod1_q;
  logic [12:0]                 n4_q;
  logic [7:0]                  q100_q;
  logic [5:0]                  q400_q;
  logic [9:0]                  q25_q;

  always_comb begin
    n_sum = 15'(year_i) + 15'(rtt_pkg::LEAP_BIAS_N);
    p100  = 26'(n_sum[14:2]) * 26'(rtt_pkg::M25);
    p400  = 24'(n_sum[14:4]) * 24'(rtt_pkg::M25);
    p25   = 27'(year_i) * 27'(rtt_pkg::M25);
    m_d   = (month_i > rtt_pkg::LAST_MONTH) ? rtt_pkg::LAST_MONTH : month_i;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      y1_q    <= year_i;
      m1_q    <= m_d;
      code1_q <= day_code_i;
      dom1_q  <= day_of_month_i;
      tgt1_q  <= weekday_i;
      tod1_q  <= time_of_day_i;
      n4_q    <= n_sum[14:2];
      q100_q  <= p100[24:rtt_pkg::M25_SH];
      q400_q  <= p400[22:rtt_pkg::M25_SH];
      q25_q   <= p25[26:rtt_pkg::M25_SH];
    end
  end

  // stage 2: days from the epoch to 1 January, days before the month
  logic [DW-1:0]                  days_y_d;
  logic [rtt_pkg::YEAR_W-1:0]     r25;
  logic                           leap;
  logic [rtt_pkg::MD_W-1:0]       md_d;

  logic signed [DW-1:0]           days_y2_q;
  logic [rtt_pkg::MD_W-1:0]       md2_q;
  logic [1:0]                     code2_q;
  logic [rtt_pkg::DOM_W-1:0]      dom2_q;
  logic [rtt_pkg::WDAY_W-1:0]     tgt2_q;
  logic [rtt_pkg::TOD_W-1:0]      tod2_q;

  always_comb begin
    days_y_d = DW'(y1_q) * DW'(rtt_pkg::YEAR_DAYS) + DW'(n4_q) - DW'(q100_q)
             + DW'(q400_q) - DW'(rtt_pkg::YEAR_OFFSET);
    r25  = y1_q - 14'(q25_q) * 14'(25);
    // divisible by 4, and not by 100 unless by 400
    leap = (y1_q[1:0] == 2'd0) && ((r25 != '0) || (y1_q[3:0] == 4'd0));
    md_d = rtt_pkg::MONTH_START[m1_q] + rtt_pkg::MD_W'((m1_q > 4'd1) && leap);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      days_y2_q <= $signed(days_y_d);
      md2_q     <= md_d;
      code2_q   <= code1_q;
      dom2_q    <= dom1_q;
      tgt2_q    <= tgt1_q;
      tod2_q    <= tod1_q;
    end
  end

  // stage 3: scale to seconds, form the weekday operand
  rtt_pkg::days_t days_d;
  logic [DW-1:0]  x_sum;

  always_comb begin
    x_sum         = DW'(days_y2_q) + DW'(md2_q) + DW'(dom2_q) + DW'(rtt_pkg::WD_OFFSET);
    days_d.s1     = rtt_pkg::SW'(days_y2_q) * rtt_pkg::SECS_SW;
    days_d.md_s   = $signed(rtt_pkg::SW'(md2_q)) * rtt_pkg::SECS_SW;
    days_d.dm_s   = $signed(rtt_pkg::SW'(dom2_q)) * rtt_pkg::SECS_SW - rtt_pkg::SECS_SW;
    days_d.x      = x_sum[rtt_pkg::X_W-1:0];
    days_d.code   = rtt_pkg::day_code_e'(code2_q);
    days_d.target = tgt2_q;
    days_d.tod    = tod2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      days_o <= days_d;
    end
  end

endmodule

>>> rtl/rtt_adjust.sv
// weekday shift, time of day and overflow stages of the transition pipeline
// depends on rtt_pkg
`timescale 1ns / 1ps

module rtt_adjust #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  rtt_pkg::days_t                    days_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [rtt_pkg::OUT_W-1:0]  transition_seconds_o,
  output logic                              overflow_o
);

  localparam int SW       = rtt_pkg::SW;
  localparam int XW       = rtt_pkg::X_W;
  localparam int OvfShift = TIME_BITS - 1;

  // true when v does not fit in a signed TIME_BITS word
  function automatic logic out_of_range(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] h;
    h = v >>> OvfShift;
    return (h != '0) && (h != '1);
  endfunction

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: month and day sums, quotient by 7
  logic [46:0]                  p7;
  logic signed [SW-1:0]         s2_d, s3_d;

  logic signed [SW-1:0]         s2_q, s3_q;
  logic                         ov1_q;
  logic [20:0]                  q7_q;
  logic [XW-1:0]                x1_q;
  rtt_pkg::day_code_e           code1_q;
  logic [rtt_pkg::WDAY_W-1:0]   tgt1_q;
  logic [rtt_pkg::TOD_W-1:0]    tod1_q;

  always_comb begin
    p7   = 47'(days_i.x) * 47'(rtt_pkg::M7);
    s2_d = days_i.s1 + days_i.md_s;
    s3_d = s2_d + days_i.dm_s;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      ov1_q   <= out_of_range(days_i.s1);
      q7_q    <= p7[46:rtt_pkg::M7_SH];
      x1_q    <= days_i.x;
      code1_q <= days_i.code;
      tgt1_q  <= days_i.target;
      tod1_q  <= days_i.tod;
    end
  end

  // stage 2: weekday of the anchor day and the shift in seconds
  logic [XW-1:0]                r7;
  logic [rtt_pkg::WDAY_W-1:0]   wd;
  logic signed [3:0]            da, db, shift_days;
  logic signed [SW-1:0]         shift_s_d;

  logic signed [SW-1:0]         s3b_q, shift_s_q;
  logic                         ov2_q;
  logic [rtt_pkg::TOD_W-1:0]    tod2_q;

  always_comb begin
    r7 = x1_q - XW'(q7_q) * XW'(7);
    wd = r7[rtt_pkg::WDAY_W-1:0];
    da = $signed({1'b0, tgt1_q}) - $signed({1'b0, wd});
    db = $signed({1'b0, wd}) - $signed({1'b0, tgt1_q});
    shift_days = 4'sd0;
    if (tgt1_q != rtt_pkg::NO_WEEKDAY) begin
      case (code1_q)
        rtt_pkg::DC_ON_AFTER:  shift_days = (da < 0) ? da + 4'sd7 : da;
        rtt_pkg::DC_ON_BEFORE: shift_days = (db < 0) ? -(db + 4'sd7) : -db;
        default:               shift_days = 4'sd0;
      endcase
    end
    shift_s_d = SW'(shift_days) * rtt_pkg::SECS_SW;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s3b_q     <= s3_q;
      shift_s_q <= shift_s_d;
      ov2_q     <= ov1_q || out_of_range(s2_q) || out_of_range(s3_q);
      tod2_q    <= tod1_q;
    end
  end

  // stage 3: weekday shift and time of day
  logic signed [SW-1:0] s4, s5;

  always_comb begin
    s4 = s3b_q + shift_s_q;
    s5 = s4 + $signed({{(SW - rtt_pkg::TOD_W){1'b0}}, tod2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      transition_seconds_o <= s5[rtt_pkg::OUT_W-1:0];
      overflow_o           <= ov2_q || out_of_range(s4) || out_of_range(s5);
    end
  end

endmodule

>>> rtl/rule_transition_time.sv
// Rule transition time: turns one yearly rule instance (year, month, day code, day of
// month, weekday, time of day) into the second since 1970-01-01 00:00 at which the
// transition falls, with a flag for any partial sum leaving the signed TIME_BITS range.
// Six register stages; a request is taken every cycle when nothing stalls. Each stage
// moves on whenever it is empty or the stage after it moves, so bubbles close up and a
// request is still taken while a finished result waits at the output. The stages follow
// the chain of constant-reciprocal divisions and the day-to-seconds multiplier.
// depends on rtt_pkg, rtt_days and rtt_adjust
`timescale 1ns / 1ps

module rule_transition_time #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [rtt_pkg::YEAR_W-1:0]        year_i,
  input  logic [rtt_pkg::MONTH_W-1:0]       month_i,
  input  logic [1:0]                        day_code_i,
  input  logic [rtt_pkg::DOM_W-1:0]         day_of_month_i,
  input  logic [rtt_pkg::WDAY_W-1:0]        weekday_i,
  input  logic [rtt_pkg::TOD_W-1:0]         time_of_day_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [rtt_pkg::OUT_W-1:0]  transition_seconds_o,
  output logic                              overflow_o
);

  rtt_pkg::days_t days;
  logic           days_valid;
  logic           days_stall;

  rtt_days u_days (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .year_i         (year_i),
    .month_i        (month_i),
    .day_code_i     (day_code_i),
    .day_of_month_i (day_of_month_i),
    .weekday_i      (weekday_i),
    .time_of_day_i  (time_of_day_i),
    .valid_o        (days_valid),
    .stall_i        (days_stall),
    .days_o         (days)
  );

  rtt_adjust #(
    .TIME_BITS (TIME_BITS)
  ) u_adjust (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (days_valid),
    .stall_o              (days_stall),
    .days_i               (days),
    .valid_o              (valid_o),
    .stall_i              (stall_i),
    .transition_seconds_o (transition_seconds_o),
    .overflow_o           (overflow_o)
  );

endmodule

>>> rtl/rtt_checker.sv
// port-level checks for rule_transition_time, attached by bind
// depends on rule_transition_time_macros.svh and rtt_pkg
`timescale 1ns / 1ps
`include "rule_transition_time_macros.svh"

module rtt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              stall_o,
  input logic                              valid_o,
  input logic                              stall_i,
  input logic signed [rtt_pkg::OUT_W-1:0]  transition_seconds_o,
  input logic                              overflow_o
);

  // a result waiting at the output stays offered
  `RTT_ASSERT(a_out_valid_held, valid_o && stall_i |=> valid_o)

  // a stalled result keeps its value
  `RTT_ASSERT(a_out_payload_held, valid_o && stall_i |=> $stable(transition_seconds_o) && $stable(overflow_o))

  // back pressure only when the pipe is full behind a stalled result
  `RTT_ASSERT(a_stall_only_when_blocked, stall_o |-> valid_o && stall_i)

  // reset empties the pipe at once
  `RTT_ASSERT_RST(a_reset_empty, !rst_ni |-> !valid_o && !stall_o)

endmodule

bind rule_transition_time rtt_checker u_rtt_checker (.*);
